@@ sv/ray_sphere_intersection_defines.svh @@
// Assertion macros shared by the ray/sphere intersection RTL.
`ifndef RAY_SPHERE_INTERSECTION_DEFINES_SVH
`define RAY_SPHERE_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSI_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RSI_ASSERT(name, prop, msg)
`define RSI_ASSERT_NEVER(name, cond, msg)
`endif
`endif

@@ sv/rsi_pkg.sv @@
// Shared constants, types and width helpers of the ray/sphere intersection block.
package rsi_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned LIMIT_W        = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned RADIUS_RESET   = 65536;
  localparam int unsigned LIMIT_RESET    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_LIMIT  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic hit;
  } tag_t;

  function automatic int unsigned cfg_w(input int unsigned cw);
    return (cw - 1 > LIMIT_W) ? cw - 1 : LIMIT_W;
  endfunction

endpackage

@@ sv/rsi_front.sv @@
// Front end: configuration registers and the pipelined quadratic and discriminant.
module rsi_front #(
  parameter int unsigned COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [rsi_pkg::cfg_w(COORD_BITS)-1:0]    cfg_data_i,
  input  logic                                     start_i,
  input  logic [2:0][COORD_BITS-1:0]               p1_i,
  input  logic [2:0][COORD_BITS-1:0]               p2_i,
  input  logic [2:0][COORD_BITS-1:0]               ctr_i,
  output rsi_pkg::tag_t                            tag_o,
  output logic [4*COORD_BITS+7:0]                  rad_o,
  output logic signed [2*COORD_BITS+3:0]           b_o,
  output logic [2*COORD_BITS+1:0]                  a_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned F   = rsi_pkg::FRAC_BITS;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned AW  = 2 * CW + 2;
  localparam int unsigned BW  = 2 * CW + 4;
  localparam int unsigned MW  = 2 * CW + 4;
  localparam int unsigned HW  = MW / 2;
  localparam int unsigned RW  = 2 * MW;
  localparam int unsigned DDW = RW + 2;
  localparam int unsigned RRW = 2 * (CW - 1);
  localparam int unsigned LW  = rsi_pkg::LIMIT_W;

  logic [CW-2:0] radius_q;
  logic [LW-1:0] limit_q;
  logic [7:1]    vld_q;

  logic signed [DW-1:0] dp_q [3];
  logic signed [DW-1:0] f_q  [3];
  logic signed [PW-1:0] paa_q [3];
  logic signed [PW-1:0] pab_q [3];
  logic signed [PW-1:0] pcc_q [3];
  logic [RRW-1:0]       rr_q;

  logic signed [BW-1:0] sab, sbb, scc;
  logic [AW-1:0]        a_q3;
  logic signed [BW-1:0] b_q3, cc_q3;

  logic [MW-1:0]        bm_q4, ccm_q4;
  logic                 ccn_q4, degen_q4;
  logic [AW-1:0]        a_q4;
  logic signed [BW-1:0] b_q4;

  logic [HW-1:0]        bl, bh, al, ah, cl, ch;
  logic [MW-1:0]        amx;
  logic [MW-1:0]        pbll_q5, pblh_q5, pbhh_q5;
  logic [MW-1:0]        pall_q5, palh_q5, pahl_q5, pahh_q5;
  logic                 ccn_q5, degen_q5;
  logic [AW-1:0]        a_q5;
  logic signed [BW-1:0] b_q5;

  logic [RW-1:0]        b2_q6, ac_q6;
  logic                 ccn_q6, degen_q6;
  logic [AW-1:0]        a_q6;
  logic signed [BW-1:0] b_q6;

  logic signed [DDW-1:0] d_c;
  logic                  hit_q7;
  logic [RW-1:0]         rad_q7;
  logic [AW-1:0]         a_q7;
  logic signed [BW-1:0]  b_q7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= (CW-1)'(rsi_pkg::RADIUS_RESET);
      limit_q  <= LW'(rsi_pkg::LIMIT_RESET);
      vld_q    <= '0;
    end else begin
      vld_q <= {vld_q[6:1], start_i};
      if (cfg_we_i) begin
        if (cfg_idx_i == rsi_pkg::CFG_RADIUS) begin
          radius_q <= cfg_data_i[CW-2:0];
        end else if (cfg_idx_i == rsi_pkg::CFG_LIMIT) begin
          limit_q <= cfg_data_i[LW-1:0];
        end
      end
    end
  end

  always_comb begin
    sab  = paa_q[0] + paa_q[1] + paa_q[2];
    sbb  = pab_q[0] + pab_q[1] + pab_q[2];
    scc  = pcc_q[0] + pcc_q[1] + pcc_q[2] - $signed({{(BW-RRW){1'b0}}, rr_q});
    bl   = bm_q4[HW-1:0];
    bh   = bm_q4[MW-1:HW];
    amx  = {{(MW-AW){1'b0}}, a_q4};
    al   = amx[HW-1:0];
    ah   = amx[MW-1:HW];
    cl   = ccm_q4[HW-1:0];
    ch   = ccm_q4[MW-1:HW];
    if (ccn_q6) begin
      d_c = $signed({2'b00, b2_q6}) + $signed({ac_q6, 2'b00});
    end else begin
      d_c = $signed({2'b00, b2_q6}) - $signed({ac_q6, 2'b00});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dp_q[i]  <= $signed({p2_i[i][CW-1], p2_i[i]}) - $signed({p1_i[i][CW-1], p1_i[i]});
      f_q[i]   <= $signed({p1_i[i][CW-1], p1_i[i]}) - $signed({ctr_i[i][CW-1], ctr_i[i]});
      paa_q[i] <= dp_q[i] * dp_q[i];
      pab_q[i] <= dp_q[i] * f_q[i];
      pcc_q[i] <= f_q[i] * f_q[i];
    end
    rr_q <= radius_q * radius_q;

    a_q3  <= sab[AW-1:0];
    b_q3  <= {sbb[BW-2:0], 1'b0};
    cc_q3 <= scc;

    bm_q4    <= b_q3[BW-1] ? MW'(-b_q3) : MW'(b_q3);
    ccm_q4   <= cc_q3[BW-1] ? MW'(-cc_q3) : MW'(cc_q3);
    ccn_q4   <= cc_q3[BW-1];
    degen_q4 <= (a_q3 == '0) || (a_q3 < (AW'(limit_q) << F));
    a_q4     <= a_q3;
    b_q4     <= b_q3;

    pbll_q5  <= bl * bl;
    pblh_q5  <= bl * bh;
    pbhh_q5  <= bh * bh;
    pall_q5  <= al * cl;
    palh_q5  <= al * ch;
    pahl_q5  <= ah * cl;
    pahh_q5  <= ah * ch;
    ccn_q5   <= ccn_q4;
    degen_q5 <= degen_q4;
    a_q5     <= a_q4;
    b_q5     <= b_q4;

    b2_q6    <= (RW'(pbhh_q5) << MW) + (RW'(pblh_q5) << (HW + 1)) + RW'(pbll_q5);
    ac_q6    <= (RW'(pahh_q5) << MW) + ((RW'(palh_q5) + RW'(pahl_q5)) << HW)
                + RW'(pall_q5);
    ccn_q6   <= ccn_q5;
    degen_q6 <= degen_q5;
    a_q6     <= a_q5;
    b_q6     <= b_q5;

    hit_q7 <= !degen_q6 && !d_c[DDW-1];
    rad_q7 <= d_c[RW-1:0];
    a_q7   <= a_q6;
    b_q7   <= b_q6;
  end

  assign tag_o = '{valid: vld_q[7], hit: hit_q7};
  assign rad_o = rad_q7;
  assign b_o   = b_q7;
  assign a_o   = a_q7;

endmodule

@@ sv/rsi_queue.sv @@
// Short transaction queue between the front end and the back end.
`include "ray_sphere_intersection_defines.svh"
module rsi_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rsi_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTRW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  cnt_q;
  logic             pop;

  assign pop = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign valid_o = pop;
  assign data_o  = mem_q[rd_ptr_q];

  `RSI_ASSERT(a_q_no_overflow, push_i |-> ((cnt_q < CNTW'(DEPTH)) || pop), "push into full queue")
  `RSI_ASSERT(a_q_cnt_range, cnt_q <= CNTW'(DEPTH), "queue count out of range")
  `RSI_ASSERT(a_q_drain, (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 1'b1), "queue drain lost")

endmodule

@@ sv/rsi_sqrt.sv @@
// Back end, first part: pipelined floor square root of the discriminant.
module rsi_sqrt #(
  parameter int unsigned COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rsi_pkg::tag_t                  tag_i,
  input  logic [4*COORD_BITS+7:0]        rad_i,
  input  logic signed [2*COORD_BITS+3:0] b_i,
  input  logic [2*COORD_BITS+1:0]        a_i,
  output rsi_pkg::tag_t                  tag_o,
  output logic [2*COORD_BITS+3:0]        root_o,
  output logic signed [2*COORD_BITS+3:0] b_o,
  output logic [2*COORD_BITS+1:0]        a_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned AW = 2 * CW + 2;
  localparam int unsigned BW = 2 * CW + 4;
  localparam int unsigned MW = 2 * CW + 4;
  localparam int unsigned RW = 2 * MW;

  logic [MW:1]          vld_q, hit_q;
  logic [MW+1:0]        rem_q  [1:MW];
  logic [MW-1:0]        root_q [1:MW];
  logic [RW-1:0]        rad_q  [1:MW];
  logic signed [BW-1:0] b_q    [1:MW];
  logic [AW-1:0]        a_q    [1:MW];

  logic [MW+1:0]        rem_s  [0:MW-1];
  logic [MW-1:0]        root_s [0:MW-1];
  logic [RW-1:0]        rad_s  [0:MW-1];
  logic signed [BW-1:0] b_s    [0:MW-1];
  logic [AW-1:0]        a_s    [0:MW-1];
  logic [MW+3:0]        r2     [0:MW-1];
  logic [MW+3:0]        trial  [0:MW-1];
  logic [MW+3:0]        diff   [0:MW-1];
  logic [MW+1:0]        rem_d  [1:MW];
  logic [MW-1:0]        root_d [1:MW];
  logic [RW-1:0]        rad_d  [1:MW];

  always_comb begin
    rem_s[0]  = '0;
    root_s[0] = '0;
    rad_s[0]  = rad_i;
    b_s[0]    = b_i;
    a_s[0]    = a_i;
    for (int k = 1; k < MW; k++) begin
      rem_s[k]  = rem_q[k];
      root_s[k] = root_q[k];
      rad_s[k]  = rad_q[k];
      b_s[k]    = b_q[k];
      a_s[k]    = a_q[k];
    end
    for (int k = 0; k < MW; k++) begin
      r2[k]    = {rem_s[k], rad_s[k][RW-1 -: 2]};
      trial[k] = {2'b00, root_s[k], 2'b01};
      diff[k]  = r2[k] - trial[k];
      if (r2[k] >= trial[k]) begin
        rem_d[k+1]  = diff[k][MW+1:0];
        root_d[k+1] = {root_s[k][MW-2:0], 1'b1};
      end else begin
        rem_d[k+1]  = r2[k][MW+1:0];
        root_d[k+1] = {root_s[k][MW-2:0], 1'b0};
      end
      rad_d[k+1] = {rad_s[k][RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= '0;
    end else begin
      vld_q <= {vld_q[MW-1:1], tag_i.valid};
      hit_q <= {hit_q[MW-1:1], tag_i.hit};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= MW; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      rad_q[k]  <= rad_d[k];
      b_q[k]    <= b_s[k-1];
      a_q[k]    <= a_s[k-1];
    end
  end

  assign tag_o  = '{valid: vld_q[MW], hit: hit_q[MW]};
  assign root_o = root_q[MW];
  assign b_o    = b_q[MW];
  assign a_o    = a_q[MW];

endmodule

@@ sv/rsi_div.sv @@
// Back end, second part: pipelined rounded divisions and saturation of both parameters.
module rsi_div #(
  parameter int unsigned COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rsi_pkg::tag_t                  tag_i,
  input  logic [2*COORD_BITS+3:0]        root_i,
  input  logic signed [2*COORD_BITS+3:0] b_i,
  input  logic [2*COORD_BITS+1:0]        a_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic signed [COORD_BITS-1:0]   mu_near_o,
  output logic signed [COORD_BITS-1:0]   mu_far_o,
  output logic                           saturated_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned F   = rsi_pkg::FRAC_BITS;
  localparam int unsigned AW  = 2 * CW + 2;
  localparam int unsigned BW  = 2 * CW + 4;
  localparam int unsigned MW  = 2 * CW + 4;
  localparam int unsigned NW  = 2 * CW + 6;
  localparam int unsigned XW  = NW + F;
  localparam int unsigned QB  = CW + 1;
  localparam int unsigned DVW = AW + 1;
  localparam int unsigned PL  = QB + 3;

  logic [PL:1] vld_q, hit_q;

  logic signed [NW-1:0] bx, sx;
  logic signed [NW-1:0] n_q1 [2];
  logic [AW-1:0]        a_q1;

  logic [XW-1:0]        x_q2  [2];
  logic [1:0]           sg_q2;
  logic [DVW-1:0]       dv_q2;

  logic [DVW-1:0]       rem_q3 [2];
  logic [QB-1:0]        low_q3 [2];
  logic [1:0]           ovf_q3, sg_q3;
  logic [DVW-1:0]       dv_q3;

  logic [DVW-1:0]       rem_q  [2][1:QB];
  logic [QB-1:0]        low_q  [2][1:QB];
  logic [QB-1:0]        quo_q  [2][1:QB];
  logic [1:0]           ovf_q  [1:QB];
  logic [1:0]           sg_q   [1:QB];
  logic [DVW-1:0]       dv_q   [1:QB];

  logic [DVW-1:0]       rem_s  [2][0:QB-1];
  logic [QB-1:0]        low_s  [2][0:QB-1];
  logic [QB-1:0]        quo_s  [2][0:QB-1];
  logic [1:0]           ovf_s  [0:QB-1];
  logic [1:0]           sg_s   [0:QB-1];
  logic [DVW-1:0]       dv_s   [0:QB-1];
  logic [DVW:0]         r2     [2][0:QB-1];
  logic [DVW:0]         diff   [2][0:QB-1];
  logic                 ge     [2][0:QB-1];

  logic [NW-1:0]        mag    [2];
  logic [XW-QB-1:0]     hi     [2];
  logic [QB-1:0]        quo    [2];
  logic [1:0]           sat;
  logic signed [CW-1:0] mu     [2];
  logic [QB-1:0]        pos_lim, neg_lim;

  assign bx      = {{(NW-BW){b_i[BW-1]}}, b_i};
  assign sx      = {{(NW-MW){1'b0}}, root_i};
  assign pos_lim = {2'b00, {(CW-1){1'b1}}};
  assign neg_lim = {2'b01, {(CW-1){1'b0}}};

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      mag[j] = n_q1[j][NW-1] ? NW'(-n_q1[j]) : NW'(n_q1[j]);
      hi[j]  = x_q2[j][XW-1:QB];
      rem_s[j][0] = rem_q3[j];
      low_s[j][0] = low_q3[j];
      quo_s[j][0] = '0;
      for (int k = 1; k < QB; k++) begin
        rem_s[j][k] = rem_q[j][k];
        low_s[j][k] = low_q[j][k];
        quo_s[j][k] = quo_q[j][k];
      end
      for (int k = 0; k < QB; k++) begin
        r2[j][k]   = {rem_s[j][k], low_s[j][k][QB-1]};
        diff[j][k] = r2[j][k] - {1'b0, dv_s[k]};
        ge[j][k]   = (r2[j][k] >= {1'b0, dv_s[k]});
      end
      quo[j] = quo_q[j][QB];
      if (sg_q[QB][j]) begin
        sat[j] = ovf_q[QB][j] || (quo[j] > neg_lim);
        mu[j]  = sat[j] ? {1'b1, {(CW-1){1'b0}}} : -quo[j][CW-1:0];
      end else begin
        sat[j] = ovf_q[QB][j] || (quo[j] > pos_lim);
        mu[j]  = sat[j] ? {1'b0, {(CW-1){1'b1}}} : quo[j][CW-1:0];
      end
    end
    ovf_s[0] = ovf_q3;
    sg_s[0]  = sg_q3;
    dv_s[0]  = dv_q3;
    for (int k = 1; k < QB; k++) begin
      ovf_s[k] = ovf_q[k];
      sg_s[k]  = sg_q[k];
      dv_s[k]  = dv_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      hit_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[PL-1:1], tag_i.valid};
      hit_q  <= {hit_q[PL-1:1], tag_i.hit};
      done_o <= vld_q[PL];
    end
  end

  always_ff @(posedge clk_i) begin
    n_q1[0] <= -bx + sx;
    n_q1[1] <= -bx - sx;
    a_q1    <= a_i;

    dv_q2 <= {a_q1, 1'b0};
    dv_q3 <= dv_q2;
    for (int j = 0; j < 2; j++) begin
      x_q2[j]   <= {mag[j], {F{1'b0}}} + XW'(a_q1);
      sg_q2[j]  <= n_q1[j][NW-1];
      ovf_q3[j] <= (hi[j] >= dv_q2);
      rem_q3[j] <= DVW'(hi[j]);
      low_q3[j] <= x_q2[j][QB-1:0];
      sg_q3[j]  <= sg_q2[j];
      for (int k = 1; k <= QB; k++) begin
        rem_q[j][k] <= ge[j][k-1] ? diff[j][k-1][DVW-1:0] : r2[j][k-1][DVW-1:0];
        low_q[j][k] <= {low_s[j][k-1][QB-2:0], 1'b0};
        quo_q[j][k] <= {quo_s[j][k-1][QB-2:0], ge[j][k-1]};
      end
    end
    for (int k = 1; k <= QB; k++) begin
      ovf_q[k] <= ovf_s[k-1];
      sg_q[k]  <= sg_s[k-1];
      dv_q[k]  <= dv_s[k-1];
    end

    hit_o       <= hit_q[PL];
    mu_near_o   <= hit_q[PL] ? mu[0] : '0;
    mu_far_o    <= hit_q[PL] ? mu[1] : '0;
    saturated_o <= hit_q[PL] && (sat[0] || sat[1]);
  end

endmodule

@@ sv/ray_sphere_intersection.sv @@
// Top level of the ray/sphere intersection block.
// Usage:
//   Raise start_i with the segment start, segment end and sphere centre on the
//   coordinate ports (signed Q15.16). A transaction is taken at each edge with
//   start_i high and busy_o low; busy_o stays low, so one transaction enters
//   every cycle.
//   Each transaction gives one result: done_o is high for exactly one cycle
//   with hit_o, mu_near_o, mu_far_o and saturated_o. Results leave in order.
//   Each transaction passes through the seven-stage quadratic front end, the queue,
//   the one-bit-per-stage square root (2*COORD_BITS+4 stages) and the rounding
//   divider (COORD_BITS+5 stages).
//   Throughput is one transaction per cycle.
//   The receiver cannot stall: results are shown once and not held.
//   Write sphere_radius (index 0) and degenerate_limit (index 1) through
//   cfg_we_i, cfg_idx_i and cfg_data_i while no transaction is in flight.
//   Reset sets the radius to 1.0 and the limit to 1 and empties the pipeline.
`include "ray_sphere_intersection_defines.svh"
module ray_sphere_intersection #(
  parameter int unsigned COORD_BITS = rsi_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [COORD_BITS-1:0]          start_x_i,
  input  logic signed [COORD_BITS-1:0]          start_y_i,
  input  logic signed [COORD_BITS-1:0]          start_z_i,
  input  logic signed [COORD_BITS-1:0]          end_x_i,
  input  logic signed [COORD_BITS-1:0]          end_y_i,
  input  logic signed [COORD_BITS-1:0]          end_z_i,
  input  logic signed [COORD_BITS-1:0]          centre_x_i,
  input  logic signed [COORD_BITS-1:0]          centre_y_i,
  input  logic signed [COORD_BITS-1:0]          centre_z_i,
  input  logic                                  cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [rsi_pkg::cfg_w(COORD_BITS)-1:0] cfg_data_i,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic signed [COORD_BITS-1:0]          mu_near_o,
  output logic signed [COORD_BITS-1:0]          mu_far_o,
  output logic                                  saturated_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned AW  = 2 * CW + 2;
  localparam int unsigned BW  = 2 * CW + 4;
  localparam int unsigned MW  = 2 * CW + 4;
  localparam int unsigned RW  = 2 * MW;
  localparam int unsigned QW  = 1 + RW + BW + AW;

  logic [2:0][CW-1:0]   p1, p2, ctr;
  rsi_pkg::tag_t        f_tag, s_in_tag, s_tag;
  logic [RW-1:0]        f_rad;
  logic signed [BW-1:0] f_b, s_b;
  logic [AW-1:0]        f_a, s_a;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic                 q_valid;
  logic [MW-1:0]        s_root;

  assign busy_o  = 1'b0;
  assign p1      = {start_z_i, start_y_i, start_x_i};
  assign p2      = {end_z_i, end_y_i, end_x_i};
  assign ctr     = {centre_z_i, centre_y_i, centre_x_i};
  assign q_wdata = {f_tag.hit, f_rad, f_b, f_a};

  rsi_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i && !busy_o),
    .p1_i       (p1),
    .p2_i       (p2),
    .ctr_i      (ctr),
    .tag_o      (f_tag),
    .rad_o      (f_rad),
    .b_o        (f_b),
    .a_o        (f_a)
  );

  rsi_queue #(
    .WIDTH (QW),
    .DEPTH (rsi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_tag.valid),
    .data_i  (q_wdata),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign s_in_tag = '{valid: q_valid, hit: q_rdata[QW-1]};

  rsi_sqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s_in_tag),
    .rad_i  (q_rdata[QW-2 -: RW]),
    .b_i    ($signed(q_rdata[AW +: BW])),
    .a_i    (q_rdata[AW-1:0]),
    .tag_o  (s_tag),
    .root_o (s_root),
    .b_o    (s_b),
    .a_o    (s_a)
  );

  rsi_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (s_tag),
    .root_i      (s_root),
    .b_i         (s_b),
    .a_i         (s_a),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .mu_near_o   (mu_near_o),
    .mu_far_o    (mu_far_o),
    .saturated_o (saturated_o)
  );

  `RSI_ASSERT(a_miss_zero, (done_o && !hit_o) |-> ((mu_near_o == '0) && (mu_far_o == '0)), "miss with nonzero parameters")
  `RSI_ASSERT_NEVER(a_sat_needs_hit, done_o && saturated_o && !hit_o, "saturation flagged on a miss")
  `RSI_ASSERT(a_mu_order, (done_o && hit_o) |-> (mu_near_o >= mu_far_o), "near parameter below far parameter")

endmodule

@@ test/ray_sphere_intersection_tb.sv @@
// Self-checking testbench for the ray/sphere intersection block.
module ray_sphere_intersection_tb;

  localparam int CW = 32;
  localparam int DW = rsi_pkg::cfg_w(CW);
  localparam int ONE = 65536;
  localparam int LATENCY = 3 * CW + 17;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t ray_t [9];
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic   hit;
    coord_t mu_near;
    coord_t mu_far;
    logic   sat;
  } hit_t;

  class hit_scoreboard;
    hit_t pending[$];
    logic [30:0] radius;
    logic [15:0] limit;
    int errors;

    function new();
      radius = 31'(rsi_pkg::RADIUS_RESET);
      limit = 16'(rsi_pkg::LIMIT_RESET);
      errors = 0;
    endfunction

    function void set_reg(rsi_pkg::cfg_idx_e idx, logic [DW-1:0] data);
      if (idx == rsi_pkg::CFG_RADIUS) radius = data[30:0];
      else if (idx == rsi_pkg::CFG_LIMIT) limit = data[15:0];
    endfunction

    function wide_t widen(coord_t v);
      return {{(256-CW){v[CW-1]}}, v};
    endfunction

    function wide_t isqrt(wide_t v);
      logic [255:0] n, res, bit_w;
      n = v;
      res = '0;
      bit_w = 256'd1 << 254;
      while (bit_w != 0 && bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (n >= res + bit_w) begin
          n = n - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    function coord_t round_sat(wide_t num, wide_t den, inout logic sat);
      wide_t mag, q, hi, lo;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) q = -q;
      hi = widen({1'b0, {(CW-1){1'b1}}});
      lo = widen({1'b1, {(CW-1){1'b0}}});
      if (q > hi) begin
        sat = 1'b1;
        q = hi;
      end else if (q < lo) begin
        sat = 1'b1;
        q = lo;
      end
      return q[CW-1:0];
    endfunction

    function void note_ray(ray_t r);
      wide_t a, b, c, d, s, dp, f, rr;
      hit_t h;
      a = 0; b = 0; c = 0;
      for (int i = 0; i < 3; i++) begin
        dp = widen(r[3+i]) - widen(r[i]);
        f = widen(r[i]) - widen(r[6+i]);
        a = a + dp * dp;
        b = b + dp * f;
        c = c + f * f;
      end
      b = 2 * b;
      rr = {225'd0, radius};
      c = c - rr * rr;
      d = b * b - 4 * a * c;
      h = '{1'b0, '0, '0, 1'b0};
      if (a != 0 && a >= ({240'd0, limit} <<< rsi_pkg::FRAC_BITS) && d >= 0) begin
        s = isqrt(d);
        h.hit = 1'b1;
        h.mu_near = round_sat((s - b) <<< rsi_pkg::FRAC_BITS, 2 * a, h.sat);
        h.mu_far = round_sat((-b - s) <<< rsi_pkg::FRAC_BITS, 2 * a, h.sat);
      end
      pending = {pending, h};
    endfunction

    function void check_hit(hit_t got);
      hit_t exp_h;
      if (pending.size() == 0) begin
        $error("unexpected result: hit=%0b mu_near=%0d", got.hit, got.mu_near);
        errors++;
        return;
      end
      exp_h = pending.pop_front();
      if (got.hit !== exp_h.hit) begin
        $error("hit: expected %0b, got %0b", exp_h.hit, got.hit);
        errors++;
      end
      if (got.mu_near !== exp_h.mu_near) begin
        $error("mu_near: expected %0d, got %0d", exp_h.mu_near, got.mu_near);
        errors++;
      end
      if (got.mu_far !== exp_h.mu_far) begin
        $error("mu_far: expected %0d, got %0d", exp_h.mu_far, got.mu_far);
        errors++;
      end
      if (got.sat !== exp_h.sat) begin
        $error("saturated: expected %0b, got %0b", exp_h.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  coord_t sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0, cx = '0, cy = '0, cz = '0;
  logic cfg_we_i = 1'b0;
  rsi_pkg::cfg_idx_e cfg_idx_i = rsi_pkg::CFG_RADIUS;
  logic [DW-1:0] cfg_data_i = '0;
  logic done_o, hit_o, saturated_o;
  coord_t mu_near_o, mu_far_o;

  hit_scoreboard sb = new();
  int cycles = 0;
  bit idling = 1'b1;

  ray_sphere_intersection #(.COORD_BITS(CW)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .centre_x_i(cx), .centre_y_i(cy), .centre_z_i(cz),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .hit_o, .mu_near_o, .mu_far_o, .saturated_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_sphere_intersection_tb: errors");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_data_i);
      if (start_i && !busy_o) sb.note_ray('{sx, sy, sz, ex, ey, ez, cx, cy, cz});
      if (done_o) sb.check_hit('{hit_o, mu_near_o, mu_far_o, saturated_o});
    end
  end

  function automatic ray_t mk(int a0, int a1, int a2, int a3, int a4, int a5,
                              int a6, int a7, int a8);
    return '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
  endfunction

  function automatic coord_t near_val(coord_t base, int span);
    return base + coord_t'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      foreach (r[i]) r[i] = $urandom;
    end else begin
      for (int i = 0; i < 3; i++) begin
        r[6+i] = near_val('0, 1 << 24);
        r[i] = near_val(r[6+i], 1 << 22);
        r[3+i] = near_val(r[i], 1 << 20);
      end
      if (sel == 9) r[3] = r[0] + $urandom_range(0, 3);
    end
    return r;
  endfunction

  task automatic send_ray(ray_t r);
    while (idling && $urandom_range(0, 99) < 13) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    {sx, sy, sz} <= {r[0], r[1], r[2]};
    {ex, ey, ez} <= {r[3], r[4], r[5]};
    {cx, cy, cz} <= {r[6], r[7], r[8]};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(rsi_pkg::cfg_idx_e idx, logic [DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [DW-1:0] radii[6];
    logic [DW-1:0] limits[6];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_ray(mk(-2*ONE, ONE, 0, 2*ONE, ONE, 0, 0, 0, 0));
    send_ray(mk(-2*ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0));
    send_ray(mk(-2*ONE, 3*ONE, 0, 2*ONE, 3*ONE, 0, 0, 0, 0));
    send_ray(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0));
    send_ray(mk(0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_ray(mk(0, 0, 0, 256, 0, 0, 1 << 30, 0, 0));
    send_ray(mk(0, 0, 0, 256, 0, 0, -(1 << 30), 0, 0));
    send_ray(mk(2*ONE, 0, 0, 3*ONE, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) begin
      ray_t r;
      foreach (r[k]) r[k] = ((i + k) % 2) ? 32'h7fffffff : 32'h80000000;
      send_ray(r);
      foreach (r[k]) r[k] = ((i + k) % 2) ? 32'haaaaaaaa : 32'h55555555;
      send_ray(r);
    end
    send_ray(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 0, 0, 0));
    send_ray(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 0, 0, 0));
    drain();

    radii = '{DW'(0), DW'(32'h7fffffff), DW'(1 << 20), DW'(ONE),
              DW'($urandom_range(1 << 14, 1 << 22)), DW'($urandom)};
    limits = '{DW'(0), DW'(16'hffff), DW'(0), DW'(1), DW'($urandom_range(0, 255)),
               DW'($urandom)};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rsi_pkg::CFG_RADIUS, radii[ph]);
      write_reg(rsi_pkg::CFG_LIMIT, limits[ph]);
      idling = (ph != 2);
      send_ray(mk(-2*ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0));
      for (int n = 0; n < 170; n++) send_ray(random_ray());
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ray_sphere_intersection_tb: clean");
    end else begin
      $display("ray_sphere_intersection_tb: errors");
    end
    $finish;
  end

endmodule

@@ ray_sphere_intersection.f @@
+incdir+sv
sv/rsi_pkg.sv
sv/rsi_front.sv
sv/rsi_queue.sv
sv/rsi_sqrt.sv
sv/rsi_div.sv
sv/ray_sphere_intersection.sv
test/ray_sphere_intersection_tb.sv
